// ===== design/sss_pkg.sv =====
package sss_pkg;

  localparam int unsigned PRICE_W     = 32;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned STACK_DEPTH = 64;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef struct packed {
    logic                      valid;
    logic signed [PRICE_W-1:0] price;
    logic        [POS_W-1:0]   pos;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_POP,
    OP_PUSH,
    OP_CLEAR
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

// ===== design/stock_span_stream.sv =====
// An accepted price is registered, then top entries priced at or below it are popped, each once;
// then it is pushed and its span registered as the result once the output is free, with no new
// beat taken before that. The pop loop runs one entry per cycle through the cell chain.
// Reset (rst_n low, synchronous): stack empty, position and overflow flag cleared,
// no result pending. Stack payload is not reset.
module stock_span_stream #(
  parameter int unsigned STACK_DEPTH = sss_pkg::STACK_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sss_pkg::PRICE_W-1:0] in_tdata,   // [31:0] price
  input  logic                        in_tuser,   // [0] new_series
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sss_pkg::POS_W-1:0]   out_tdata,  // [31:0] span
  output logic                        out_tuser   // [0] overflowed
);
  import sss_pkg::*;

  state_t                    state_r, state_nxt;
  logic signed [PRICE_W-1:0] price_r, price_nxt;
  logic        [POS_W-1:0]   position_r, position_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic        [POS_W-1:0]   span_r, span_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  cell_op_t op;
  entry_t   push_entry;
  entry_t   top;
  logic     full;
  logic     pop_hit;
  logic     out_free;

  sss_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .push_entry (push_entry),
    .top        (top),
    .full       (full)
  );

  assign push_entry.valid = 1'b1;
  assign push_entry.price = price_r;
  assign push_entry.pos   = position_r;

  assign pop_hit  = top.valid && (top.price <= price_r);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    price_nxt     = price_r;
    position_nxt  = position_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    span_nxt      = span_r;
    out_ovf_nxt   = out_ovf_r;
    op            = OP_HOLD;
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          price_nxt = in_tdata;
          state_nxt = ST_RUN;
          if (in_tuser) begin
            op           = OP_CLEAR;
            position_nxt = '0;
            ovf_nxt      = 1'b0;
          end
        end
      end
      ST_RUN: begin
        if (pop_hit) begin
          op = OP_POP;
        end else if (out_free) begin
          op = OP_PUSH;
          if (!top.valid) begin
            span_nxt = (position_r == POS_MAX) ? POS_MAX : position_r + POS_W'(1);
          end else begin
            span_nxt = (position_r > top.pos) ? position_r - top.pos : POS_W'(1);
          end
          ovf_nxt       = ovf_r | full;
          out_ovf_nxt   = ovf_r | full;
          out_valid_nxt = 1'b1;
          if (position_r != POS_MAX) begin
            position_nxt = position_r + POS_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      position_r  <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      position_r  <= position_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r   <= price_nxt;
    span_r    <= span_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = span_r;
  assign out_tuser  = out_ovf_r;

endmodule

// ===== design/sss_cell.sv =====
module sss_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  sss_pkg::cell_op_t op,
  input  sss_pkg::entry_t  from_up,
  input  sss_pkg::entry_t  from_down,
  output sss_pkg::entry_t  entry
);
  import sss_pkg::*;

  logic                      valid_r, valid_nxt;
  logic signed [PRICE_W-1:0] price_r, price_nxt;
  logic        [POS_W-1:0]   pos_r, pos_nxt;

  always_comb begin
    valid_nxt = valid_r;
    price_nxt = price_r;
    pos_nxt   = pos_r;
    case (op)
      OP_POP: begin
        valid_nxt = from_down.valid;
        price_nxt = from_down.price;
        pos_nxt   = from_down.pos;
      end
      OP_PUSH: begin
        valid_nxt = from_up.valid;
        price_nxt = from_up.price;
        pos_nxt   = from_up.pos;
      end
      OP_CLEAR: begin
        valid_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    pos_r   <= pos_nxt;
  end

  assign entry.valid = valid_r;
  assign entry.price = price_r;
  assign entry.pos   = pos_r;

endmodule

// ===== design/sss_stack.sv =====
module sss_stack #(
  parameter int unsigned STACK_DEPTH = sss_pkg::STACK_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sss_pkg::cell_op_t op,
  input  sss_pkg::entry_t   push_entry,
  output sss_pkg::entry_t   top,
  output logic              full
);
  import sss_pkg::*;

  entry_t cells [STACK_DEPTH];
  entry_t empty_entry;

  assign empty_entry = '0;

  // cell 0 is the top of the stack; push shifts toward the bottom, pop toward the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t up_d, down_d;
    if (i == 0) begin : g_top
      assign up_d = push_entry;
    end else begin : g_mid_up
      assign up_d = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign down_d = empty_entry;
    end else begin : g_mid_down
      assign down_d = cells[i+1];
    end
    sss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .from_up   (up_d),
      .from_down (down_d),
      .entry     (cells[i])
    );
  end

  assign top  = cells[0];
  assign full = cells[STACK_DEPTH-1].valid;

endmodule

// ===== design/sss_checker.sv =====
module sss_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [sss_pkg::POS_W-1:0]   out_tdata,
  input logic                        out_tuser
);
  import sss_pkg::*;

  // one price in flight: no second beat right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on back-to-back cycles");

  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata != '0)
    else $error("zero span");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind stock_span_stream sss_checker u_sss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/stock_span_stream_tb.sv =====
module stock_span_stream_tb;
  import sss_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] span;
    logic             overflowed;
  } span_result_t;

  typedef enum int {
    SER_WIDE,
    SER_NARROW,
    SER_FALL,
    SER_RISE,
    SER_WAVE,
    SER_EDGE
  } series_kind_t;

  class span_board_t;
    logic signed [PRICE_W-1:0] stk_price [STACK_DEPTH];
    logic        [POS_W-1:0]   stk_pos   [STACK_DEPTH];
    int unsigned               depth_used;
    logic        [POS_W-1:0]   next_pos;
    logic                      ovf_seen;
    span_result_t              expected [$];
    int                        errors;

    function new();
      depth_used = 0;
      next_pos   = '0;
      ovf_seen   = 1'b0;
      errors     = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void note_price(input logic signed [PRICE_W-1:0] price, input logic new_series);
      span_result_t r;
      logic [POS_W-1:0] top_pos;
      if (new_series) begin
        depth_used = 0;
        next_pos   = '0;
        ovf_seen   = 1'b0;
      end
      while (depth_used > 0 && stk_price[depth_used-1] <= price)
        depth_used--;
      if (depth_used == 0) begin
        r.span = (next_pos == POS_MAX) ? POS_MAX : next_pos + 1;
      end else begin
        top_pos = stk_pos[depth_used-1];
        r.span  = (next_pos > top_pos) ? next_pos - top_pos : 1;
      end
      // full stack: drop the bottom entry
      if (depth_used >= STACK_DEPTH) begin
        for (int k = 0; k < STACK_DEPTH - 1; k++) begin
          stk_price[k] = stk_price[k+1];
          stk_pos[k]   = stk_pos[k+1];
        end
        depth_used = STACK_DEPTH - 1;
        ovf_seen   = 1'b1;
      end
      stk_price[depth_used] = price;
      stk_pos[depth_used]   = next_pos;
      depth_used++;
      if (next_pos != POS_MAX)
        next_pos++;
      r.overflowed = ovf_seen;
      expected.insert(expected.size(), r);
    endfunction

    task report(input string what);
      if (errors < 50)
        $display("mismatch @%0t: %s", $time, what);
      errors++;
    endtask

    task check_result(input logic [POS_W-1:0] span, input logic overflowed);
      span_result_t exp;
      if (expected.size() == 0) begin
        report($sformatf("unexpected beat, span %0d overflowed %0b", span, overflowed));
      end else begin
        exp = expected.pop_front();
        if (span !== exp.span)
          report($sformatf("span got %0d expected %0d", span, exp.span));
        if (overflowed !== exp.overflowed)
          report($sformatf("overflowed got %b expected %b", overflowed, exp.overflowed));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [PRICE_W-1:0] in_tdata;
  logic               in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [POS_W-1:0]   out_tdata;
  logic               out_tuser;

  span_board_t board = new();
  int          burst_left = 0;

  stock_span_stream i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic offer(input logic [PRICE_W-1:0] price, input logic new_series);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= price;
    in_tuser  <= new_series;
    do @(posedge clk); while (!in_tready);
    board.note_price(price, new_series);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin : feed_prices
    int                        fed;
    int                        len;
    int                        period;
    bit                        paused;
    series_kind_t              kind;
    logic signed [PRICE_W-1:0] level;
    logic signed [PRICE_W-1:0] price;
    logic                      ns;
    logic        [PRICE_W-1:0] corner_vals [8];

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    corner_vals = '{32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                    32'h0000_0001, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h5555_AAAA};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // from reset, no series start
    offer(32'h0000_0000, 1'b0);
    offer(32'hFFFF_FFFF, 1'b0);
    offer(32'h7FFF_FFFF, 1'b0);
    offer(32'h8000_0000, 1'b0);
    offer(32'h8000_0000, 1'b0);
    offer(32'h8000_0000, 1'b0);
    offer(32'h0000_0000, 1'b0);
    offer(32'h0000_0000, 1'b0);
    offer(32'h7FFF_FFFF, 1'b0);
    offer(32'h0000_0005, 1'b1);
    offer(32'h0000_0003, 1'b0);
    offer(32'h0000_0002, 1'b0);
    offer(32'h0000_0004, 1'b0);
    offer(32'h0000_0004, 1'b0);
    offer(32'h0000_0006, 1'b0);
    offer(32'h8000_0000, 1'b1);
    offer(32'h7FFF_FFFF, 1'b1);
    offer(32'h7FFF_FFFE, 1'b0);
    offer(32'hFFFF_FFFE, 1'b0);
    offer(32'hFFFF_FFFF, 1'b0);
    wait_drained();

    fed    = 0;
    paused = 1'b0;
    while (fed < 1630) begin
      kind  = series_kind_t'($urandom_range(0, 5));
      level = $urandom;
      case (kind)
        SER_WIDE:   len = $urandom_range(5, 40);
        SER_NARROW: len = $urandom_range(10, 60);
        SER_FALL:   len = $urandom_range(70, 160);
        SER_RISE:   len = $urandom_range(5, 30);
        SER_WAVE:   len = $urandom_range(10, 50);
        default:    len = $urandom_range(5, 20);
      endcase
      period = $urandom_range(3, 12);
      for (int i = 0; i < len; i++) begin
        case (kind)
          SER_WIDE:   price = $urandom;
          SER_NARROW: price = int'($urandom_range(0, 8)) - 4;
          SER_FALL: begin
            if ($urandom_range(0, 15) == 0)
              level = level + $urandom_range(1, 20);
            else
              level = level - (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3));
            price = level;
          end
          SER_RISE: begin
            level = level + $urandom_range(0, 5000);
            price = level;
          end
          SER_WAVE:   price = level + (i * 3 - (i % period) * 7);
          default:    price = corner_vals[$urandom_range(0, 7)];
        endcase
        // series starts, plus a stray restart now and then
        ns = (i == 0) || ($urandom_range(0, 49) == 0);
        offer(price, ns);
        fed++;
      end
      if (!paused && fed >= 800) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (board.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin : drain_results
    int unsigned cyc;
    int unsigned got;
    int          mode;
    logic        take;
    cyc  = 0;
    got  = 0;
    mode = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      take = rst_n && out_tvalid && out_tready;
      if (take) begin
        board.check_result(out_tdata, out_tuser);
        got++;
      end
      // long hold-off so the block backs up into its input
      if (take && (got == 300 || got == 1100)) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      cyc++;
      if (cyc % 50 == 0)
        mode = $urandom_range(0, 3);
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ~out_tready;
      endcase
    end
  end

endmodule
